@@ design/dpad_pkg.sv @@
// ----------------------------------------------------------------------------
// dpad_pkg
// Constants, tables and zone laws for the dew point / air density unit.
// ----------------------------------------------------------------------------
package dpad_pkg;

   // dew point fixed point: 0.1 F times 6300000
   // half step plus 2048 steps, keeps the dividend non-negative
   localparam logic [35:0] DEW_BIAS  = 36'd12905550000;
   // quotient by 6300000 taken as (dividend >> 5) / 196875
   localparam logic [17:0] DEW_DIV5  = 18'd196875;
   // floor(2^30 / 196875), estimate is low by at most one
   localparam logic [12:0] DEW_RCP   = 13'd5453;
   localparam logic [18:0] DEW_REM2  = 19'd393750;
   // 32 F offset; one degree C step is 18 * 6300000, taken as (e >> 6) / 1771875
   localparam logic [35:0] IDX_OFS   = 36'd2016000000;
   localparam logic [20:0] IDX_DIV6  = 21'd1771875;
   // floor(2^27 / 1771875), estimate is low by at most one
   localparam logic [6:0]  IDX_RCP   = 7'd75;
   localparam logic [35:0] IDX_SAT   = 36'd4422600000;
   localparam logic [5:0]  IDX_MAX   = 6'd39;

   localparam logic [9:0]  HUM_MAX   = 10'd1000;
   localparam logic [5:0]  ALT_MAX   = 6'd49;

   // density: (P - W) * 7480000 = S * baro * 635 - Wt * 748000
   localparam logic [9:0]  PRS_MUL   = 10'd635;
   localparam logic [28:0] VAP_MUL   = 29'd748000;
   localparam logic [24:0] DENS_K1   = 25'd31766553;
   localparam logic [28:0] DENS_HALF = 29'd284240000;
   localparam logic [29:0] DENS_DEN  = 30'd568480000;
   localparam logic [15:0] DENS_MAX  = 16'd20000;
   localparam logic [16:0] TEMP_OFS  = 17'd22970;

   // saturation moisture times 300, from temperature in 0.1 F
   function automatic logic signed [20:0] sat_moisture(input logic signed [11:0] t);
      logic signed [20:0] tt;
      logic signed [20:0] r;
      tt = 21'(t);
      if (tt > 21'sd800)      r = (tt - 21'sd600) * 21'sd225;
      else if (tt > 21'sd500) r = (tt - 21'sd350) * 21'sd100;
      else if (tt > 21'sd400) r = tt * 21'sd45 - 21'sd7500;
      else if (tt > 21'sd300) r = tt * 21'sd21 + 21'sd2100;
      else if (tt > 21'sd200) r = tt * 21'sd60 - 21'sd9600;
      else                    r = tt * 21'sd30;
      return r;
   endfunction

   // dew point in 0.1 F times 6300000, from moisture times 300000
   function automatic logic signed [35:0] dew_scaled(input logic signed [31:0] w);
      logic signed [35:0] ww;
      logic signed [35:0] r;
      ww = 36'(w);
      if (ww > 36'sd45000000)      r = ww * 36'sd28 + 36'sd3780000000;
      else if (ww > 36'sd15000000) r = ww * 36'sd63 + 36'sd2205000000;
      else if (ww > 36'sd10500000) r = (ww + 36'sd7500000) * 36'sd140;
      else if (ww > 36'sd8400000)  r = ww * 36'sd300 - 36'sd630000000;
      else if (ww > 36'sd6000000)  r = ww * 36'sd105 + 36'sd1008000000;
      else                         r = ww * 36'sd210;
      return r;
   endfunction

   // water vapour pressure in 0.1 mmHg per degree C
   function automatic logic [9:0] vapour_tenths(input logic [5:0] c);
      logic [9:0] r;
      unique case (c)
         6'd0: r = 10'd46;   6'd1: r = 10'd49;   6'd2: r = 10'd53;   6'd3: r = 10'd57;
         6'd4: r = 10'd61;   6'd5: r = 10'd65;   6'd6: r = 10'd70;   6'd7: r = 10'd75;
         6'd8: r = 10'd80;   6'd9: r = 10'd86;   6'd10: r = 10'd92;  6'd11: r = 10'd99;
         6'd12: r = 10'd105; 6'd13: r = 10'd112; 6'd14: r = 10'd120; 6'd15: r = 10'd128;
         6'd16: r = 10'd136; 6'd17: r = 10'd145; 6'd18: r = 10'd155; 6'd19: r = 10'd165;
         6'd20: r = 10'd176; 6'd21: r = 10'd187; 6'd22: r = 10'd198; 6'd23: r = 10'd211;
         6'd24: r = 10'd224; 6'd25: r = 10'd238; 6'd26: r = 10'd252; 6'd27: r = 10'd268;
         6'd28: r = 10'd284; 6'd29: r = 10'd301; 6'd30: r = 10'd319; 6'd31: r = 10'd337;
         6'd32: r = 10'd357; 6'd33: r = 10'd378; 6'd34: r = 10'd400; 6'd35: r = 10'd422;
         6'd36: r = 10'd446; 6'd37: r = 10'd471; 6'd38: r = 10'd498; 6'd39: r = 10'd525;
         default: r = 10'd525;
      endcase
      return r;
   endfunction

   // standard pressure in 0.01 inHg per 100 ft step
   function automatic logic [11:0] std_press(input logic [5:0] a);
      logic [11:0] r;
      unique case (a)
         6'd0: r = 12'd2992;  6'd1: r = 12'd2981;  6'd2: r = 12'd2970;  6'd3: r = 12'd2960;
         6'd4: r = 12'd2949;  6'd5: r = 12'd2938;  6'd6: r = 12'd2928;  6'd7: r = 12'd2917;
         6'd8: r = 12'd2907;  6'd9: r = 12'd2896;  6'd10: r = 12'd2885; 6'd11: r = 12'd2875;
         6'd12: r = 12'd2864; 6'd13: r = 12'd2854; 6'd14: r = 12'd2844; 6'd15: r = 12'd2833;
         6'd16: r = 12'd2823; 6'd17: r = 12'd2813; 6'd18: r = 12'd2802; 6'd19: r = 12'd2792;
         6'd20: r = 12'd2782; 6'd21: r = 12'd2772; 6'd22: r = 12'd2762; 6'd23: r = 12'd2752;
         6'd24: r = 12'd2742; 6'd25: r = 12'd2731; 6'd26: r = 12'd2721; 6'd27: r = 12'd2711;
         6'd28: r = 12'd2701; 6'd29: r = 12'd2691; 6'd30: r = 12'd2682; 6'd31: r = 12'd2672;
         6'd32: r = 12'd2662; 6'd33: r = 12'd2652; 6'd34: r = 12'd2642; 6'd35: r = 12'd2632;
         6'd36: r = 12'd2623; 6'd37: r = 12'd2613; 6'd38: r = 12'd2603; 6'd39: r = 12'd2594;
         6'd40: r = 12'd2584; 6'd41: r = 12'd2574; 6'd42: r = 12'd2565; 6'd43: r = 12'd2556;
         6'd44: r = 12'd2546; 6'd45: r = 12'd2537; 6'd46: r = 12'd2527; 6'd47: r = 12'd2518;
         6'd48: r = 12'd2508; 6'd49: r = 12'd2499;
         default: r = 12'd2499;
      endcase
      return r;
   endfunction

endpackage

@@ design/dew_point_air_density_unit.sv @@
// ----------------------------------------------------------------------------
// dew_point_air_density_unit
// Pipelined dew point and air density estimator, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one sensor sample per transfer (temperature, humidity,
//    altitude step, barometer); rsp_* returns dew point and air density.
//  - Fixed 33-stage pipeline: a sample taken into the first stage moves
//    through every stage to rsp_tvalid. One sample per cycle is taken while the output flows.
//  - Latency is set by the density quotient: the stages of operand prep,
//    16 restoring divider steps (divisor from temperature), one output
//    register. Dew point and table index use reciprocal multiply with a
//    one-step correction (3 stages), then ride a delay line.
//  - The whole pipeline advances as one; when rsp_tready is low with a
//    result waiting, every stage holds and req_tready drops, so nothing is
//    lost or repeated. Bubbles travel as cleared valid bits.
//  - Synchronous reset clears all valid bits; the datapath needs no reset.
//  - Out-of-range humidity saturates to 100.0 %, altitude to step 49;
//    density saturates to 20000 and is zero where vapour pressure
//    reaches the station pressure.
// ----------------------------------------------------------------------------
module dew_point_air_density_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // temp_tenths_f[11:0], humidity_tenths_pct[21:12], altitude_step[27:22],
   // baro_hundredths_inhg[39:28]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // dew_point_tenths_f[11:0], density_ten_thousandths[26:12], zero fill
   output logic [31:0] rsp_tdata
);

   localparam int LAST = 33;

   logic            en;
   logic [LAST:1]   vld_ff;

   assign en         = !vld_ff[LAST] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAST-1:1], req_tvalid};
      end
   end

   // input clamps
   logic [9:0] hum_in;
   logic [5:0] alt_in;
   assign hum_in = (req_tdata[21:12] > dpad_pkg::HUM_MAX) ? dpad_pkg::HUM_MAX
                                                          : req_tdata[21:12];
   assign alt_in = (req_tdata[27:22] > dpad_pkg::ALT_MAX) ? dpad_pkg::ALT_MAX
                                                          : req_tdata[27:22];

   // stage registers
   logic signed [11:0] t1_ff;
   logic [9:0]         h1_ff, h2_ff;
   logic [5:0]         a1_ff;
   logic [11:0]        b1_ff;
   logic signed [20:0] v2_ff;
   logic [23:0]        sb2_ff;
   logic [15:0]        m_ff [2:13];
   logic [33:0]        sbk_ff [3:12];
   logic signed [31:0] w3_ff;
   logic signed [35:0] dx4_ff;
   logic [29:0]        dn5_ff, dn6_ff;
   logic [41:0]        dp6_ff;
   logic [11:0]        dq7_ff;
   logic [18:0]        dr7_ff;
   logic [27:0]        er5_ff, er6_ff;
   logic [32:0]        ep6_ff;
   logic [5:0]         cq7_ff;
   logic [21:0]        cr7_ff;
   logic [5:0]         cq_ff [8:11];
   logic               epos_ff [0:6];
   logic               esat_ff [0:6];
   logic [9:0]         wv12_ff;
   logic               qpos_ff [13:32];
   logic [32:0]        q13_ff;
   logic [41:0]        lo14_ff;
   logic [40:0]        hi14_ff;
   logic [44:0]        h_ff [14:15];
   logic [45:0]        dv_ff [14:32];
   logic [57:0]        num15_ff;
   logic [58:0]        nr_ff [0:16];
   logic [15:0]        nq_ff [0:16];
   logic [11:0]        dqc_ff [8:32];
   logic [11:0]        rsp_dew_ff;
   logic [14:0]        rsp_dens_ff;

   // combinational next values
   logic signed [16:0] m2_in;
   logic signed [35:0] e5_in;
   logic [35:0]        a5_in;
   logic [29:0]        dr7_in;
   logic [27:0]        cr7_in;
   logic [5:0]         idx11_in;
   logic [34:0]        qq13_in;
   logic [58:0]        nr_in [1:16];
   logic [15:0]        nq_in [1:16];
   logic [14:0]        dens_in;

   assign m2_in = 17'(t1_ff) * 17'sd5 + $signed(dpad_pkg::TEMP_OFS);
   assign a5_in = 36'(dx4_ff) + dpad_pkg::DEW_BIAS;
   assign e5_in = dx4_ff - $signed(dpad_pkg::IDX_OFS);

   // remainders after the reciprocal estimate, below twice the divisor
   assign dr7_in = dn6_ff - 30'(dp6_ff[41:30]) * 30'(dpad_pkg::DEW_DIV5);
   assign cr7_in = er6_ff - 28'(ep6_ff[32:27]) * 28'(dpad_pkg::IDX_DIV6);

   assign idx11_in = !epos_ff[6] ? 6'd0 :
                     esat_ff[6]  ? dpad_pkg::IDX_MAX : cq_ff[11];

   assign qq13_in = 35'(sbk_ff[12]) - 35'(wv12_ff * dpad_pkg::VAP_MUL);

   // density divider: divisor follows temperature, 16 quotient bits
   always_comb begin
      logic [61:0] nd;
      for (int j = 0; j < 16; j++) begin
         nd = 62'(dv_ff[16+j]) << (15 - j);
         if (62'(nr_ff[j]) >= nd) begin
            nr_in[j+1] = nr_ff[j] - nd[58:0];
            nq_in[j+1] = {nq_ff[j][14:0], 1'b1};
         end else begin
            nr_in[j+1] = nr_ff[j];
            nq_in[j+1] = {nq_ff[j][14:0], 1'b0};
         end
      end
   end

   assign dens_in = !qpos_ff[32] ? 15'd0 :
                    (nq_ff[16] > dpad_pkg::DENS_MAX) ? dpad_pkg::DENS_MAX[14:0]
                                                     : nq_ff[16][14:0];

   always_ff @(posedge clock) begin
      if (en) begin
         // P1: sample
         t1_ff <= $signed(req_tdata[11:0]);
         h1_ff <= hum_in;
         a1_ff <= alt_in;
         b1_ff <= req_tdata[39:28];
         // P2: moisture law, pressure product, density temperature term
         v2_ff    <= dpad_pkg::sat_moisture(t1_ff);
         h2_ff    <= h1_ff;
         sb2_ff   <= dpad_pkg::std_press(a1_ff) * b1_ff;
         m_ff[2]  <= m2_in[15:0];
         // P3
         w3_ff     <= $signed(32'(v2_ff)) * $signed(32'({1'b0, h2_ff}));
         sbk_ff[3] <= 34'(sb2_ff) * 34'(dpad_pkg::PRS_MUL);
         // P4: inverse law
         dx4_ff <= dpad_pkg::dew_scaled(w3_ff);
         // P5: divider operands, low bits are a power-of-two factor of the divisor
         dn5_ff     <= a5_in[34:5];
         er5_ff     <= e5_in[33:6];
         epos_ff[0] <= (e5_in > 36'sd0);
         esat_ff[0] <= (e5_in >= $signed(dpad_pkg::IDX_SAT));
         // P6: reciprocal products
         dp6_ff <= 42'(dn5_ff) * 42'(dpad_pkg::DEW_RCP);
         dn6_ff <= dn5_ff;
         ep6_ff <= 33'(er5_ff) * 33'(dpad_pkg::IDX_RCP);
         er6_ff <= er5_ff;
         // P7: quotient estimates and remainders
         dq7_ff <= dp6_ff[41:30];
         dr7_ff <= dr7_in[18:0];
         cq7_ff <= ep6_ff[32:27];
         cr7_ff <= cr7_in[21:0];
         // P8: one-step correction
         dqc_ff[8] <= dq7_ff + 12'(dr7_ff >= dpad_pkg::DEW_DIV5);
         cq_ff[8]  <= cq7_ff + 6'(cr7_ff >= dpad_pkg::IDX_DIV6);
         for (int k = 9; k <= 11; k++) cq_ff[k] <= cq_ff[k-1];
         for (int j = 1; j <= 6; j++) begin
            epos_ff[j] <= epos_ff[j-1];
            esat_ff[j] <= esat_ff[j-1];
         end
         for (int k = 3; k <= 13; k++) m_ff[k] <= m_ff[k-1];
         for (int k = 4; k <= 12; k++) sbk_ff[k] <= sbk_ff[k-1];
         // P12: vapour pressure
         wv12_ff <= dpad_pkg::vapour_tenths(idx11_in);
         // P13: pressure difference
         q13_ff      <= qq13_in[32:0];
         qpos_ff[13] <= !qq13_in[34] && (qq13_in != '0);
         // P14: partial products
         lo14_ff    <= q13_ff[16:0] * dpad_pkg::DENS_K1;
         hi14_ff    <= q13_ff[32:17] * dpad_pkg::DENS_K1;
         h_ff[14]   <= m_ff[13] * dpad_pkg::DENS_HALF;
         dv_ff[14]  <= m_ff[13] * dpad_pkg::DENS_DEN;
         // P15, P16: numerator plus half divisor for rounding
         num15_ff <= {hi14_ff, 17'd0} + 58'(lo14_ff);
         h_ff[15] <= h_ff[14];
         nr_ff[0] <= 59'(num15_ff) + 59'(h_ff[15]);
         nq_ff[0] <= '0;
         for (int j = 1; j <= 16; j++) begin
            nr_ff[j] <= nr_in[j];
            nq_ff[j] <= nq_in[j];
         end
         for (int k = 14; k <= 32; k++) qpos_ff[k] <= qpos_ff[k-1];
         for (int k = 15; k <= 32; k++) dv_ff[k] <= dv_ff[k-1];
         for (int k = 9; k <= 32; k++) dqc_ff[k] <= dqc_ff[k-1];
         // P33: result
         rsp_dew_ff  <= {~dqc_ff[32][11], dqc_ff[32][10:0]};
         rsp_dens_ff <= dens_in;
      end
   end

   assign rsp_tdata = {5'd0, rsp_dens_ff, rsp_dew_ff};

   // checks
   a_dew_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[7] |-> dr7_ff < dpad_pkg::DEW_REM2)
      else $error("dew quotient estimate off by more than one");

   a_dens_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[32] && qpos_ff[32] |-> 62'(nr_ff[16]) < 62'(dv_ff[32]))
      else $error("density divider remainder out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[1])
      else $error("accepted sample not captured");

endmodule

@@ test/dew_point_air_density_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dew_point_air_density_unit_test
// Self-checking bench: drives sensor samples over the request stream with
// random gaps, predicts dew point and density in exact integer arithmetic,
// and checks every response transfer in order under random back-pressure.
// ----------------------------------------------------------------------------
module dew_point_air_density_unit_test;

   localparam int LATENCY = 33;

   typedef struct packed {
      logic [11:0] baro;
      logic [5:0]  alt;
      logic [9:0]  hum;
      logic signed [11:0] temp;
   } sample_type;

   typedef struct packed {
      logic [14:0] density;
      logic signed [11:0] dew;
   } weather_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   weather_type expected_weather[$];
   int       mismatches = 0;
   bit       sending_done = 1'b0;

   dew_point_air_density_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("Regression FAIL");
      $finish;
   end

   // vapour pressure in 0.1 mmHg per degree C
   function automatic longint vapour_at(int c);
      int vt[40] = '{46, 49, 53, 57, 61, 65, 70, 75, 80, 86,
                     92, 99, 105, 112, 120, 128, 136, 145, 155, 165,
                     176, 187, 198, 211, 224, 238, 252, 268, 284, 301,
                     319, 337, 357, 378, 400, 422, 446, 471, 498, 525};
      return vt[c];
   endfunction

   // standard pressure in 0.01 inHg per 100 ft step
   function automatic longint pressure_at(int a);
      int pt[50] = '{2992, 2981, 2970, 2960, 2949, 2938, 2928, 2917,
                     2907, 2896, 2885, 2875, 2864, 2854, 2844, 2833,
                     2823, 2813, 2802, 2792, 2782, 2772, 2762, 2752,
                     2742, 2731, 2721, 2711, 2701, 2691, 2682, 2672,
                     2662, 2652, 2642, 2632, 2623, 2613, 2603, 2594,
                     2584, 2574, 2565, 2556, 2546, 2537, 2527, 2518,
                     2508, 2499};
      return pt[a];
   endfunction

   function automatic weather_type predict_weather(sample_type s);
      longint t, hum, alt, v, w, dx, dew, cnum, c, q;
      longint unsigned num, den, dens;
      int idx;
      weather_type r;
      t = s.temp;
      hum = (s.hum > 1000) ? 1000 : s.hum;
      alt = (s.alt > 49) ? 49 : s.alt;
      // six-zone moisture law, times 300
      if (t > 800) v = (t - 600) * 225;
      else if (t > 500) v = (t - 350) * 100;
      else if (t > 400) v = 45 * t - 7500;
      else if (t > 300) v = 21 * t + 2100;
      else if (t > 200) v = 60 * t - 9600;
      else v = 30 * t;
      w = v * hum;
      // inverse law, dew point times 6300000
      if (w > 45000000) dx = 28 * w + 600 * 64'd6300000;
      else if (w > 15000000) dx = 63 * w + 350 * 64'd6300000;
      else if (w > 10500000) dx = 140 * (w + 7500000);
      else if (w > 8400000) dx = 300 * w - 100 * 64'd6300000;
      else if (w > 6000000) dx = 105 * w + 160 * 64'd6300000;
      else dx = 210 * w;
      // floor division of the rounded value
      dew = dx + 3150000;
      if (dew < 0) dew = -((-dew + 6299999) / 6300000);
      else dew = dew / 6300000;
      if (dew > 2047) dew = 2047;
      if (dew < -2048) dew = -2048;
      cnum = (dx - 320 * 64'd6300000) * 5;
      if (cnum <= 0) idx = 0;
      else begin
         c = cnum / (90 * 64'd6300000);
         idx = (c > 39) ? 39 : int'(c);
      end
      q = pressure_at(int'(alt)) * longint'(s.baro) * 635 - vapour_at(idx) * 748000;
      if (q <= 0) dens = 0;
      else begin
         num = 64'd317665530 * q;
         den = longint'(5 * t + 22970) * 64'd5684800000;
         dens = (num + den / 2) / den;
         if (dens > 20000) dens = 20000;
      end
      r.dew = dew[11:0];
      r.density = dens[14:0];
      return r;
   endfunction

   function automatic int gap_length();
      if ($urandom_range(9) == 0) return $urandom_range(40, 5);
      return ($urandom_range(2) == 0) ? $urandom_range(2) : 0;
   endfunction

   // response side: random stalls, in-order comparison
   initial begin : check_responses
      weather_type exp_w, got_w;
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got_w = rsp_tdata[26:0];
            if (expected_weather.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
            end else begin
               exp_w = expected_weather.pop_front();
               if (got_w.dew !== exp_w.dew || got_w.density !== exp_w.density) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: dew exp %0d got %0d, density exp %0d got %0d",
                              exp_w.dew, got_w.dew, exp_w.density, got_w.density);
               end
            end
         end
         // stretches of full flow alternate with random stalls
         if (($urandom_range(400) < 100) || sending_done) stall = 0;
         else stall = gap_length();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
            @(posedge clock);
            // a transfer cannot happen while tready is low; just continue
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(sample_type s, bit with_gaps);
      int gap;
      gap = with_gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {s.baro, s.alt, s.hum, s.temp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_weather.push_back(predict_weather(s));
   endtask

   function automatic sample_type make_sample(int t, int h, int a, int b);
      sample_type s;
      s.temp = t[11:0]; s.hum = h[9:0]; s.alt = a[5:0]; s.baro = b[11:0];
      return s;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_weather.size() != 0) @(posedge clock);
   endtask

   // field extremes, every zone, saturations and ties
   task automatic test_directed();
      int temps[12] = '{-400, 0, 200, 201, 300, 301, 400, 401, 500, 501, 800, 1300};
      foreach (temps[i]) send_sample(make_sample(temps[i], 500, i * 4, 2992), 1'b0);
      send_sample(make_sample(-2048, 0, 0, 0), 1'b0);
      send_sample(make_sample(2047, 1023, 63, 4095), 1'b0);
      send_sample(make_sample(1300, 1000, 49, 2000), 1'b0);
      send_sample(make_sample(1300, 1000, 49, 100), 1'b0);   // density zero
      send_sample(make_sample(-400, 0, 0, 4095), 1'b0);      // density saturates
      send_sample(make_sample(700, 1000, 0, 3200), 1'b0);
      send_sample(make_sample(900, 1010, 55, 2500), 1'b1);
      send_sample(make_sample(-1, 700, 10, 3000), 1'b1);
      drain();
   endtask

   task automatic test_random(int count, bit wild);
      sample_type s;
      repeat (count) begin
         if (wild) s = {$urandom(), 8'($urandom())};
         else s = make_sample($urandom_range(1700) - 400, $urandom_range(1000),
                              $urandom_range(49), $urandom_range(3200, 2000));
         send_sample(s, 1'b1);
      end
   endtask

   // the sender holds off until every expected response has arrived
   task automatic test_hold_off();
      test_random(40, 1'b0);
      drain();
      test_random(40, 1'b1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1500, 1'b0);
      test_hold_off();
      test_random(370, 1'b1);
      drain();
      sending_done = 1'b1;
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_weather.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/dpad_pkg.sv
design/dew_point_air_density_unit.sv
test/dew_point_air_density_unit_test.sv
